>>> hw/rtl/bcrc_pkg.sv
package bcrc_pkg;

    localparam int CRC_W        = 32;
    localparam int BYTE_W       = 8;
    localparam int TRAILER_LEN  = 5;
    localparam int IDX_W        = $clog2(TRAILER_LEN);

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'h82f6_3b78;
    localparam logic [CRC_W-1:0] MASK_DELTA = 32'ha282_ead8;
    localparam logic [CRC_W-1:0] CRC_INIT   = 32'hffff_ffff;
    localparam int               ROT_RIGHT  = 15;
    localparam int               ROT_LEFT   = 17;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRAILER_LEN - 1);

    typedef enum logic
    {
        MODE_GEN   = 1'b0,
        MODE_CHECK = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        STATUS_OK       = 2'd0,
        STATUS_BAD_COMP = 2'd1,
        STATUS_MISMATCH = 2'd2
    } status_t;

    typedef enum logic
    {
        KIND_BYTE    = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    // one burst of results handed to the output stage
    typedef struct packed
    {
        kind_t              kind;
        logic [CRC_W-1:0]   crc;
        status_t            status;
    } bcrc_load_t;

    // reflected CRC32C, one byte
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = acc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] crc_mask(input logic [CRC_W-1:0] c);
        logic [CRC_W-1:0] r;
        r = (c >> ROT_RIGHT) | (c << ROT_LEFT);
        return r + MASK_DELTA;
    endfunction

endpackage

>>> hw/rtl/bcrc_out.sv
module bcrc_out
    import bcrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  bcrc_load_t          load_data,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BYTE_W-1:0]   out_byte,
    output logic [CRC_W-1:0]    masked_crc,
    output logic [1:0]          check_status,
    output logic                result_kind,
    output logic                is_last
);

    logic               valid_reg;
    logic [IDX_W-1:0]   idx_reg;
    kind_t              kind_reg;
    logic [CRC_W-1:0]   crc_reg;
    status_t            status_reg;
    logic               last_w;

    assign last_w   = (kind_reg == KIND_VERDICT) || (idx_reg == LAST_IDX);
    assign can_load = !valid_reg || (out_ready && last_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && out_ready)
        begin
            // advance through the trailer bytes, drop after the last one
            if (last_w)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= load_data.kind;
            crc_reg    <= load_data.crc;
            status_reg <= load_data.status;
        end
    end

    always_comb
    begin
        out_byte = '0;
        if (kind_reg == KIND_BYTE)
        begin
            unique case (idx_reg)
                3'd1:    out_byte = crc_reg[7:0];
                3'd2:    out_byte = crc_reg[15:8];
                3'd3:    out_byte = crc_reg[23:16];
                3'd4:    out_byte = crc_reg[31:24];
                default: out_byte = '0;
            endcase
        end
    end

    assign out_valid    = valid_reg;
    assign masked_crc   = crc_reg;
    assign check_status = status_reg;
    assign result_kind  = kind_reg;
    assign is_last      = last_w;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("result loaded while a burst is still pending");

    a_verdict_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (kind_reg == KIND_VERDICT) |-> is_last)
        else $error("verdict not marked last");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg <= LAST_IDX))
        else $error("trailer byte index out of range");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_ready && last_w && !load |=> !valid_reg)
        else $error("output still valid after last result taken");

endmodule

>>> hw/rtl/block_trailer_crc32c_masked.sv
// Latency: a closing item's first result is valid the cycle after it is accepted.
// Throughput: one body byte per cycle while input ready is high; a generate close yields five
// trailer bytes and a check trailer yields one verdict, both sent out by the output stage.
// Input ready drops while a result burst is pending, except as its last item leaves.
// Reset (rst_n, async, active low) sets the CRC to all ones, clears trailer
// progress and selects generate mode.
module block_trailer_crc32c_masked
    import bcrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                is_trailer,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BYTE_W-1:0]   out_byte,
    output logic [CRC_W-1:0]    masked_crc,
    output logic [1:0]          check_status,
    output logic                result_kind,
    output logic                is_last
);

    mode_t              mode_reg;
    logic [CRC_W-1:0]   crc_acc_reg,  crc_acc_next;
    logic [2:0]         pos_reg,      pos_next;
    logic [CRC_W-1:0]   stored_reg,   stored_next;
    logic               bad_reg,      bad_next;

    logic               in_acc;
    logic               load;
    bcrc_load_t         load_data;
    logic               can_load;
    logic [CRC_W-1:0]   fold_data;
    logic [CRC_W-1:0]   fold_zero;
    logic [CRC_W-1:0]   stored_full;
    logic [CRC_W-1:0]   check_crc;
    logic [4:0]         shamt;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_load;
    assign in_acc    = in_valid && in_ready;

    assign fold_data   = crc_fold(crc_acc_reg, data_byte);
    assign fold_zero   = crc_fold(crc_acc_reg, '0);
    assign shamt       = {pos_reg[1:0] - 2'd1, 3'b000};
    assign stored_full = stored_reg | {data_byte, {(CRC_W-BYTE_W){1'b0}}};
    assign check_crc   = crc_mask(~crc_acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_GEN;
        else if (cfg_valid && cfg_ready)
            mode_reg <= mode_t'(cfg_data);
    end

    always_comb
    begin
        crc_acc_next     = crc_acc_reg;
        pos_next         = pos_reg;
        stored_next      = stored_reg;
        bad_next         = bad_reg;
        load             = 1'b0;
        load_data.kind   = KIND_BYTE;
        load_data.crc    = crc_mask(~fold_zero);
        load_data.status = STATUS_OK;

        if (in_acc)
        begin
            priority if (!is_trailer)
            begin
                crc_acc_next = fold_data;
            end
            else if (mode_reg == MODE_GEN)
            begin
                // fold compression byte zero, emit five trailer bytes, restart
                load         = 1'b1;
                crc_acc_next = CRC_INIT;
                pos_next     = '0;
                stored_next  = '0;
                bad_next     = 1'b0;
            end
            else if (pos_reg == 3'd0)
            begin
                bad_next     = (data_byte != '0);
                crc_acc_next = fold_data;
                pos_next     = 3'd1;
            end
            else if (pos_reg < 3'd4)
            begin
                stored_next = stored_reg | ({{(CRC_W-BYTE_W){1'b0}}, data_byte} << shamt);
                pos_next    = pos_reg + 3'd1;
            end
            else
            begin
                load           = 1'b1;
                load_data.kind = KIND_VERDICT;
                load_data.crc  = check_crc;
                if (bad_reg)
                    load_data.status = STATUS_BAD_COMP;
                else if (stored_full != check_crc)
                    load_data.status = STATUS_MISMATCH;
                else
                    load_data.status = STATUS_OK;
                crc_acc_next = CRC_INIT;
                pos_next     = '0;
                stored_next  = '0;
                bad_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_acc_reg <= CRC_INIT;
            pos_reg     <= '0;
            stored_reg  <= '0;
            bad_reg     <= 1'b0;
        end
        else
        begin
            crc_acc_reg <= crc_acc_next;
            pos_reg     <= pos_next;
            stored_reg  <= stored_next;
            bad_reg     <= bad_next;
        end
    end

    bcrc_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .load_data    (load_data),
        .can_load     (can_load),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .masked_crc   (masked_crc),
        .check_status (check_status),
        .result_kind  (result_kind),
        .is_last      (is_last)
    );

endmodule
